>>> src/sha2wc_pkg.sv
package sha2wc_pkg;

    localparam int ROUNDS = 64;

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // working variables a..h at v[0]..v[7], schedule window w[0] is this round's word
    typedef struct packed {
        logic [2:0]        sel;
        logic [7:0][31:0]  v;
        logic [15:0][31:0] w;
    } t_stage;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

>>> src/sha2wc_in_if.sv
interface sha2wc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [2:0]  word_select;

    modport source (output valid, output word0, output word1, output word_select,
                    input ready);
    modport sink (input valid, input word0, input word1, input word_select,
                  output ready);
endinterface

>>> src/sha2wc_out_if.sv
interface sha2wc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;

    modport source (output valid, output digest_word, input ready);
    modport sink (input valid, input digest_word, output ready);
endinterface

>>> src/sha256_two_word_compress_select_unit.sv
// SHA-256 compression of a block holding word0, word1 and fourteen zero words (no padding),
// from the standard initial value, returning the digest word picked by word_select. One
// pipeline stage per compression round, with the message schedule computed alongside in a
// sliding sixteen-word window, so a new beat is taken every cycle while the skid entry is
// free; the final add and select are combinational and feed the output register. A
// two-entry output buffer decouples the sides: input ready depends only on that buffer, and
// the pipeline keeps taking beats while one result waits to be taken.
module sha256_two_word_compress_select_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha2wc_in_if.sink     i_in,
    sha2wc_out_if.source  o_out
);

    localparam int NSTAGE = sha2wc_pkg::ROUNDS;

    logic               valid_q [NSTAGE + 1];
    sha2wc_pkg::t_stage stage_q [NSTAGE + 1];
    logic               en;

    logic               r_out_valid;
    logic [31:0]        r_out_data;
    logic               r_skid_valid;
    logic [31:0]        r_skid_data;
    logic               last_valid;
    logic [31:0]        last_digest;
    sha2wc_pkg::t_stage last_stage;

    // the whole pipeline moves unless the skid entry is occupied
    assign en         = !r_skid_valid;
    assign i_in.ready = en;

    always_comb begin
        stage_q[0].sel = i_in.word_select;
        for (int j = 0; j < 8; j++) begin
            stage_q[0].v[j] = sha2wc_pkg::IV_TABLE[j];
        end
        stage_q[0].w     = '0;
        stage_q[0].w[0]  = i_in.word0;
        stage_q[0].w[1]  = i_in.word1;
    end
    assign valid_q[0] = i_in.valid;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_round
        sha2wc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_k     (sha2wc_pkg::K_TABLE[g]),
            .i_valid (valid_q[g]),
            .i_stage (stage_q[g]),
            .o_valid (valid_q[g + 1]),
            .o_stage (stage_q[g + 1])
        );
    end

    assign last_stage  = stage_q[NSTAGE];
    assign last_valid  = valid_q[NSTAGE] && en;
    assign last_digest = last_stage.v[last_stage.sel] + sha2wc_pkg::IV_TABLE[last_stage.sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= last_valid;
                end
            end else if (!r_out_valid) begin
                r_out_valid <= last_valid;
            end else if (last_valid) begin
                // output beat stalled, park the arriving one
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && o_out.ready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else begin
                r_out_data <= last_digest;
            end
        end else if (!r_out_valid) begin
            r_out_data <= last_digest;
        end else if (last_valid) begin
            r_skid_data <= last_digest;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_word = r_out_data;

endmodule

>>> src/sha2wc_round.sv
module sha2wc_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [31:0]        i_k,
    input  logic               i_valid,
    input  sha2wc_pkg::t_stage i_stage,
    output logic               o_valid,
    output sha2wc_pkg::t_stage o_stage
);

    logic               r_valid;
    sha2wc_pkg::t_stage r_stage;
    sha2wc_pkg::t_stage n_stage;
    logic [31:0]        t1;
    logic [31:0]        t2;

    always_comb begin
        t1 = i_stage.v[7] + sha2wc_pkg::big_sigma1(i_stage.v[4])
           + sha2wc_pkg::choose(i_stage.v[4], i_stage.v[5], i_stage.v[6])
           + i_k + i_stage.w[0];
        t2 = sha2wc_pkg::big_sigma0(i_stage.v[0])
           + sha2wc_pkg::majority(i_stage.v[0], i_stage.v[1], i_stage.v[2]);

        n_stage.sel  = i_stage.sel;
        n_stage.v[7] = i_stage.v[6];
        n_stage.v[6] = i_stage.v[5];
        n_stage.v[5] = i_stage.v[4];
        n_stage.v[4] = i_stage.v[3] + t1;
        n_stage.v[3] = i_stage.v[2];
        n_stage.v[2] = i_stage.v[1];
        n_stage.v[1] = i_stage.v[0];
        n_stage.v[0] = t1 + t2;

        // slide the schedule window and append the word sixteen rounds ahead
        for (int j = 0; j < 15; j++) begin
            n_stage.w[j] = i_stage.w[j + 1];
        end
        n_stage.w[15] = sha2wc_pkg::small_sigma1(i_stage.w[14]) + i_stage.w[9]
                      + sha2wc_pkg::small_sigma0(i_stage.w[1]) + i_stage.w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
